/* hdl/slb_pkg.sv */
// slb_pkg: shared constants and register map of the stereo loop blur unit
// no dependencies; imported by stereo_loop_blur_unit
package slb_pkg;

  // loop memory geometry
  localparam int MAX_LENGTH = 65536;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);

  // sample and fixed point widths
  localparam int SAMPLE_W = 24;
  localparam int LEN_W    = 16;         // target_length, integer part of smoothed length
  localparam int FRAC_W   = 24;         // Q0.24 fraction of rate, length and blend
  localparam int SLEN_W   = LEN_W + FRAC_W;
  localparam int RATE_W   = FRAC_W + 1;
  localparam int TBL_W    = 17;         // target_blend, Q1.16
  localparam int GAIN_W   = 16;         // output_gain, Q2.14
  localparam int GAIN_FRAC = 14;

  // limits
  localparam logic [RATE_W-1:0] RATE_ONE  = RATE_W'(1) << FRAC_W;
  localparam logic [TBL_W-1:0]  BLEND_ONE = TBL_W'(1) << 16;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(11469);

  // register indexes on the configuration port
  localparam logic [2:0] REG_TARGET_LENGTH = 3'd0;
  localparam logic [2:0] REG_TARGET_BLEND  = 3'd1;
  localparam logic [2:0] REG_GLIDE_RATE    = 3'd2;
  localparam logic [2:0] REG_OUTPUT_GAIN   = 3'd3;
  localparam logic [2:0] REG_FREEZE        = 3'd4;

  // one memory word: capture and average of both channels
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] cap_r;
    logic signed [SAMPLE_W-1:0] avg_r;
    logic signed [SAMPLE_W-1:0] cap_l;
    logic signed [SAMPLE_W-1:0] avg_l;
  } slot_word_t;

endpackage

/* hdl/stereo_loop_blur_unit.sv */
// stereo_loop_blur_unit: loop blur over a circular capture/average memory
// depends on slb_pkg
//
// Usage:
//  - s_t* channel takes one stereo item: s_tdata[23:0] left, [47:24] right.
//  - m_t* channel gives one result item per input item, same packing.
//  - APB port writes target_length (0x00), target_blend (0x04),
//    glide_rate (0x08), output_gain (0x0C) and freeze (0x10); reads return
//    the register value. Write only while the block is idle.
//  - Each item goes from acceptance to the output register in these steps: memory
//    read with the length and blend products, glide sums, average product,
//    write-back, gain product, then saturation into the output register.
//    A new item is accepted only once the last one has left, as set by this
//    single read-modify-write sequencer around the one slot memory.
//  - After reset a clearing pass writes zero to all 65536 memory entries,
//    one per cycle; s_tready stays low until the pass is done.
//  - The result sits in an output register; the next item is accepted and
//    worked on while it waits, and the sequencer holds before loading a new
//    result until m_tready takes the old one.
module stereo_loop_blur_unit
  import slb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input items: [23:0] left_in, [47:24] right_in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  // result items: [23:0] left_out, [47:24] right_out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_AVG, S_UPD, S_SCALE, S_SAT
  } state_t;

  // configuration registers
  logic [LEN_W-1:0]  target_length;
  logic [TBL_W-1:0]  target_blend;
  logic [RATE_W-1:0] glide_rate;
  logic [GAIN_W-1:0] output_gain;
  logic              freeze;

  // block state
  state_t                state;
  logic [ADDR_W-1:0]     position;
  logic [ADDR_W-1:0]     clr_addr;
  logic [SLEN_W-1:0]     smoothed_length;
  logic [RATE_W-1:0]     smoothed_blend;

  // slot memory
  slot_word_t            mem [MAX_LENGTH];
  slot_word_t            mem_rdata;
  slot_word_t            mem_wdata;
  logic [ADDR_W-1:0]     mem_waddr;
  logic                  mem_we;

  // working registers
  logic signed [SAMPLE_W-1:0] in_l, in_r;
  logic [RATE_W-1:0]          rate_q;
  logic                       lneg, bneg;
  logic [SLEN_W-1:0]          lmag;
  logic [RATE_W-1:0]          bmag;
  logic [SLEN_W+RATE_W-21:0]  lp_lo, lp_hi;
  logic [2*RATE_W-1:0]        bprod;
  logic [SLEN_W-1:0]          lstep;
  logic signed [SAMPLE_W-1:0] cap_l, cap_r, avg_l, avg_r;
  logic [SAMPLE_W-1:0]        dmag_l, dmag_r;
  logic                       dneg_l, dneg_r;
  logic [SAMPLE_W+RATE_W-1:0] aprod_l, aprod_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r;
  logic [SAMPLE_W+GAIN_W-1:0] gprod_l, gprod_r;
  logic                       gneg_l, gneg_r;
  logic [SAMPLE_W-1:0]        out_l, out_r;

  // combinational helpers
  logic                       in_fire, out_free, cfg_wr;
  logic [RATE_W-1:0]          rate_c;
  logic [TBL_W-1:0]           tb_c;
  logic [SLEN_W-1:0]          tgt_len;
  logic [RATE_W-1:0]          tgt_blend;
  logic signed [SAMPLE_W-1:0] csel_l, csel_r;
  logic signed [SAMPLE_W:0]   diff_l, diff_r;
  logic [SLEN_W+RATE_W:0]     lsum;
  logic [RATE_W-1:0]          bstep;
  logic [SAMPLE_W-1:0]        astep_l, astep_r;
  logic signed [SAMPLE_W:0]   anew_l, anew_r;
  logic [ADDR_W:0]            pos1;
  logic signed [SAMPLE_W:0]   rmag_l, rmag_r;
  logic [SAMPLE_W+GAIN_W-GAIN_FRAC-1:0] rs_l, rs_r;
  logic [SAMPLE_W-1:0]        sat_l, sat_r;

  localparam logic [SAMPLE_W+GAIN_W-GAIN_FRAC-1:0] POS_MAX =
    (SAMPLE_W+GAIN_W-GAIN_FRAC)'((1 << (SAMPLE_W-1)) - 1);
  localparam logic [SAMPLE_W+GAIN_W-GAIN_FRAC-1:0] NEG_MAX =
    (SAMPLE_W+GAIN_W-GAIN_FRAC)'(1 << (SAMPLE_W-1));

  // handshakes
  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {out_r, out_l};
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      target_length <= '0;
      target_blend  <= '0;
      glide_rate    <= '0;
      output_gain   <= GAIN_RESET;
      freeze        <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TARGET_LENGTH: target_length <= pwdata[LEN_W-1:0];
        REG_TARGET_BLEND:  target_blend  <= pwdata[TBL_W-1:0];
        REG_GLIDE_RATE:    glide_rate    <= pwdata[RATE_W-1:0];
        REG_OUTPUT_GAIN:   output_gain   <= pwdata[GAIN_W-1:0];
        REG_FREEZE:        freeze        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // configuration read
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_TARGET_LENGTH: prdata = 32'(target_length);
      REG_TARGET_BLEND:  prdata = 32'(target_blend);
      REG_GLIDE_RATE:    prdata = 32'(glide_rate);
      REG_OUTPUT_GAIN:   prdata = 32'(output_gain);
      REG_FREEZE:        prdata = 32'(freeze);
      default:           prdata = '0;
    endcase
  end

  // clamped targets for the glides
  always_comb begin
    rate_c    = (glide_rate > RATE_ONE) ? RATE_ONE : glide_rate;
    tb_c      = (target_blend > BLEND_ONE) ? BLEND_ONE : target_blend;
    tgt_len   = {target_length, FRAC_W'(0)};
    tgt_blend = {tb_c, 8'd0};
  end

  // capture select and average differences from the read word
  always_comb begin
    csel_l = freeze ? mem_rdata.cap_l : in_l;
    csel_r = freeze ? mem_rdata.cap_r : in_r;
    diff_l = {csel_l[SAMPLE_W-1], csel_l} - {mem_rdata.avg_l[SAMPLE_W-1], mem_rdata.avg_l};
    diff_r = {csel_r[SAMPLE_W-1], csel_r} - {mem_rdata.avg_r[SAMPLE_W-1], mem_rdata.avg_r};
  end

  // glide steps and averages
  always_comb begin
    lsum    = {lp_hi, 20'd0} + (SLEN_W+RATE_W+1)'(lp_lo);
    bstep   = bprod[FRAC_W+RATE_W-1:FRAC_W];
    astep_l = aprod_l[FRAC_W+SAMPLE_W-1:FRAC_W];
    astep_r = aprod_r[FRAC_W+SAMPLE_W-1:FRAC_W];
    anew_l  = dneg_l ? ({avg_l[SAMPLE_W-1], avg_l} - {1'b0, astep_l})
                     : ({avg_l[SAMPLE_W-1], avg_l} + {1'b0, astep_l});
    anew_r  = dneg_r ? ({avg_r[SAMPLE_W-1], avg_r} - {1'b0, astep_r})
                     : ({avg_r[SAMPLE_W-1], avg_r} + {1'b0, astep_r});
    pos1    = {1'b0, position} + (ADDR_W+1)'(1);
    rmag_l  = res_l[SAMPLE_W-1] ? -{res_l[SAMPLE_W-1], res_l} : {res_l[SAMPLE_W-1], res_l};
    rmag_r  = res_r[SAMPLE_W-1] ? -{res_r[SAMPLE_W-1], res_r} : {res_r[SAMPLE_W-1], res_r};
  end

  // gain shift and saturation
  always_comb begin
    rs_l = gprod_l[SAMPLE_W+GAIN_W-1:GAIN_FRAC];
    rs_r = gprod_r[SAMPLE_W+GAIN_W-1:GAIN_FRAC];
    if (!gneg_l) begin
      sat_l = (rs_l > POS_MAX) ? POS_MAX[SAMPLE_W-1:0] : rs_l[SAMPLE_W-1:0];
    end else begin
      sat_l = (rs_l > NEG_MAX) ? NEG_MAX[SAMPLE_W-1:0] : SAMPLE_W'(0) - rs_l[SAMPLE_W-1:0];
    end
    if (!gneg_r) begin
      sat_r = (rs_r > POS_MAX) ? POS_MAX[SAMPLE_W-1:0] : rs_r[SAMPLE_W-1:0];
    end else begin
      sat_r = (rs_r > NEG_MAX) ? NEG_MAX[SAMPLE_W-1:0] : SAMPLE_W'(0) - rs_r[SAMPLE_W-1:0];
    end
  end

  // memory write source: clearing pass or write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = position;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (state == S_UPD) begin
      mem_we          = 1'b1;
      mem_wdata.cap_l = cap_l;
      mem_wdata.avg_l = anew_l[SAMPLE_W-1:0];
      mem_wdata.cap_r = cap_r;
      mem_wdata.avg_r = anew_r[SAMPLE_W-1:0];
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      mem_rdata <= mem[position];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      clr_addr        <= '0;
      position        <= '0;
      smoothed_length <= '0;
      smoothed_blend  <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      // result taken; in S_SAT the load below sets valid again
      if (m_tvalid && m_tready && state != S_SAT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(MAX_LENGTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            in_l   <= s_tdata[SAMPLE_W-1:0];
            in_r   <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
            rate_q <= rate_c;
            lneg   <= tgt_len < smoothed_length;
            lmag   <= (tgt_len < smoothed_length) ? smoothed_length - tgt_len
                                                  : tgt_len - smoothed_length;
            bneg   <= tgt_blend < smoothed_blend;
            bmag   <= (tgt_blend < smoothed_blend) ? smoothed_blend - tgt_blend
                                                   : tgt_blend - smoothed_blend;
            state  <= S_MUL1;
          end
        end
        S_MUL1: begin
          lp_lo  <= {25'd0, lmag[19:0]} * {20'd0, rate_q};
          lp_hi  <= {25'd0, lmag[SLEN_W-1:20]} * {20'd0, rate_q};
          bprod  <= {25'd0, bmag} * {25'd0, rate_q};
          cap_l  <= csel_l;
          cap_r  <= csel_r;
          avg_l  <= mem_rdata.avg_l;
          avg_r  <= mem_rdata.avg_r;
          dneg_l <= diff_l[SAMPLE_W];
          dneg_r <= diff_r[SAMPLE_W];
          dmag_l <= diff_l[SAMPLE_W] ? SAMPLE_W'(-diff_l) : diff_l[SAMPLE_W-1:0];
          dmag_r <= diff_r[SAMPLE_W] ? SAMPLE_W'(-diff_r) : diff_r[SAMPLE_W-1:0];
          state  <= S_MUL2;
        end
        S_MUL2: begin
          lstep          <= lsum[SLEN_W+FRAC_W-1:FRAC_W];
          smoothed_blend <= bneg ? smoothed_blend - bstep : smoothed_blend + bstep;
          state          <= S_AVG;
        end
        S_AVG: begin
          smoothed_length <= lneg ? smoothed_length - lstep : smoothed_length + lstep;
          aprod_l <= {25'd0, dmag_l} * {24'd0, smoothed_blend};
          aprod_r <= {25'd0, dmag_r} * {24'd0, smoothed_blend};
          state   <= S_UPD;
        end
        S_UPD: begin
          res_l <= anew_l[SAMPLE_W-1:0];
          res_r <= anew_r[SAMPLE_W-1:0];
          // wrap at the integer loop length or at the memory end
          if (32'(pos1) >= 32'(smoothed_length[SLEN_W-1:FRAC_W]) ||
              32'(pos1) >= 32'(MAX_LENGTH)) begin
            position <= '0;
          end else begin
            position <= pos1[ADDR_W-1:0];
          end
          state <= S_SCALE;
        end
        S_SCALE: begin
          gneg_l  <= res_l[SAMPLE_W-1];
          gneg_r  <= res_r[SAMPLE_W-1];
          gprod_l <= {16'd0, rmag_l[SAMPLE_W-1:0]} * {24'd0, output_gain};
          gprod_r <= {16'd0, rmag_r[SAMPLE_W-1:0]} * {24'd0, output_gain};
          state   <= S_SAT;
        end
        S_SAT: begin
          if (out_free) begin
            out_l    <= sat_l;
            out_r    <= sat_r;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for stereo_loop_blur_unit, stream items in and out, apb setup
// depends on slb_pkg and stereo_loop_blur_unit; predicts each blurred pair and compares in order
module tb_top
  import slb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_CAP   = 40;
  localparam int IDLE_PCT    = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] right_val;
    logic signed [SAMPLE_W-1:0] left_val;
  } stereo_pair_t;

  // clock, reset and block inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // register shadow
  logic [LEN_W-1:0]  cfg_length = '0;
  logic [TBL_W-1:0]  cfg_blend  = '0;
  logic [RATE_W-1:0] cfg_rate   = '0;
  logic [GAIN_W-1:0] cfg_gain   = GAIN_RESET;
  logic              cfg_freeze = 1'b0;

  // loop state as the block should hold it
  int     loop_pos;
  longint smooth_len;
  longint smooth_blend;
  logic signed [SAMPLE_W-1:0] avg_left  [MAX_LENGTH];
  logic signed [SAMPLE_W-1:0] avg_right [MAX_LENGTH];
  logic signed [SAMPLE_W-1:0] cap_left  [MAX_LENGTH];
  logic signed [SAMPLE_W-1:0] cap_right [MAX_LENGTH];

  stereo_pair_t expected_pairs[$];
  int  err_count;
  int  cycle_count;
  bit  steady;
  int  hold_request;
  int  stall_left;

  stereo_loop_blur_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < PRINT_CAP)
      $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // one-pole step: cur moves toward tgt by floor(|tgt - cur| * rate / 2^24)
  function automatic longint glide_step(input longint cur, input longint tgt,
                                        input longint unsigned rate);
    longint unsigned d;
    if (tgt >= cur) begin
      d = longint'(tgt - cur);
      return cur + longint'((d * rate) >> FRAC_W);
    end
    d = longint'(cur - tgt);
    return cur - longint'((d * rate) >> FRAC_W);
  endfunction

  // average times gain, magnitude truncated, saturated to the sample range
  function automatic logic signed [SAMPLE_W-1:0] apply_gain(input longint avg,
                                                            input longint unsigned gain);
    longint unsigned mag;
    longint r;
    mag = (avg >= 0) ? avg : -avg;
    r = longint'((mag * gain) >> GAIN_FRAC);
    if (avg < 0) r = -r;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return SAMPLE_W'(r);
  endfunction

  function automatic stereo_pair_t blur_predict(input logic signed [SAMPLE_W-1:0] l_in,
                                                input logic signed [SAMPLE_W-1:0] r_in);
    longint unsigned rate;
    longint unsigned tblend;
    int slot;
    stereo_pair_t res;
    rate   = (cfg_rate > RATE_ONE) ? RATE_ONE : cfg_rate;
    tblend = (cfg_blend > BLEND_ONE) ? BLEND_ONE : cfg_blend;
    slot   = loop_pos % MAX_LENGTH;
    smooth_len   = glide_step(smooth_len, longint'(cfg_length) << FRAC_W, rate);
    smooth_blend = glide_step(smooth_blend, longint'(tblend) << 8, rate);
    if (!cfg_freeze) begin
      cap_left[slot]  = l_in;
      cap_right[slot] = r_in;
    end
    avg_left[slot]  = SAMPLE_W'(glide_step(avg_left[slot], cap_left[slot], smooth_blend));
    avg_right[slot] = SAMPLE_W'(glide_step(avg_right[slot], cap_right[slot], smooth_blend));
    res.left_val  = apply_gain(avg_left[slot], cfg_gain);
    res.right_val = apply_gain(avg_right[slot], cfg_gain);
    // wrap on the integer part of the glided length, or at the memory end
    loop_pos = slot + 1;
    if (longint'(loop_pos) >= (smooth_len >> FRAC_W) || loop_pos >= MAX_LENGTH)
      loop_pos = 0;
    return res;
  endfunction

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      REG_TARGET_LENGTH: return (32'd1 << LEN_W) - 1;
      REG_TARGET_BLEND:  return (32'd1 << TBL_W) - 1;
      REG_GLIDE_RATE:    return (32'd1 << RATE_W) - 1;
      REG_OUTPUT_GAIN:   return (32'd1 << GAIN_W) - 1;
      REG_FREEZE:        return 32'd1;
      default:           return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] shadow_value(input logic [2:0] idx);
    case (idx)
      REG_TARGET_LENGTH: return 32'(cfg_length);
      REG_TARGET_BLEND:  return 32'(cfg_blend);
      REG_GLIDE_RATE:    return 32'(cfg_rate);
      REG_OUTPUT_GAIN:   return 32'(cfg_gain);
      REG_FREEZE:        return 32'(cfg_freeze);
      default:           return 32'd0;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int near_zero;
    near_zero = $urandom_range(64);
    case ($urandom_range(9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return SAMPLE_W'(near_zero - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // apb read: setup then access, data taken at the completing edge
  task automatic read_register(input logic [2:0] idx, output logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // apb write with junk above the register width, then read back if the register is mapped
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    mask = reg_mask(idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & ~mask) | (value & mask);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_TARGET_LENGTH: cfg_length = LEN_W'(value);
      REG_TARGET_BLEND:  cfg_blend  = TBL_W'(value);
      REG_GLIDE_RATE:    cfg_rate   = RATE_W'(value);
      REG_OUTPUT_GAIN:   cfg_gain   = GAIN_W'(value);
      REG_FREEZE:        cfg_freeze = value[0];
      default: ;
    endcase
    if (idx <= REG_FREEZE) begin
      read_register(idx, got);
      if (got !== shadow_value(idx)) report_mismatch("register readback", got, shadow_value(idx));
    end
  endtask

  task automatic write_all(input logic [31:0] len_v, input logic [31:0] blend_v,
                           input logic [31:0] rate_v, input logic [31:0] gain_v,
                           input logic [31:0] frz_v);
    write_register(REG_TARGET_LENGTH, len_v);
    write_register(REG_TARGET_BLEND, blend_v);
    write_register(REG_GLIDE_RATE, rate_v);
    write_register(REG_OUTPUT_GAIN, gain_v);
    write_register(REG_FREEZE, frz_v);
  endtask

  // offer one stereo item; returns at the accepting edge with valid still high
  task automatic offer_pair(input logic signed [SAMPLE_W-1:0] l_in,
                            input logic signed [SAMPLE_W-1:0] r_in);
    @(negedge clk);
    if (!steady)
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    s_tvalid <= 1'b1;
    s_tdata  <= {r_in, l_in};
    do @(posedge clk); while (!s_tready);
    expected_pairs.push_back(blur_predict(l_in, r_in));
  endtask

  task automatic offer_random(input int count);
    for (int i = 0; i < count; i++) offer_pair(pick_sample(), pick_sample());
  endtask

  // drop valid and hold until every result is back
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(negedge clk);
  endtask

  // result ready: random idling, long hold-offs on request
  always @(negedge clk) begin
    if (hold_request > 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!steady && $urandom_range(99) < IDLE_PCT) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    stereo_pair_t got;
    stereo_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_pairs.size() == 0) begin
        report_mismatch("result with nothing expected", got, 0);
      end else begin
        want = expected_pairs.pop_front();
        if (got.left_val !== want.left_val)
          report_mismatch("left_out", got.left_val, want.left_val);
        if (got.right_val !== want.right_val)
          report_mismatch("right_out", got.right_val, want.right_val);
      end
    end
  end

  // defaults after reset, zero length and zero rate give silence in slot 0
  task automatic test_reset_values();
    logic [31:0] got;
    for (int i = REG_TARGET_LENGTH; i <= REG_FREEZE; i++) begin
      read_register(3'(i), got);
      if (got !== shadow_value(3'(i))) report_mismatch("reset value", got, shadow_value(3'(i)));
    end
    offer_pair(24'sh7FFFFF, 24'sh800000);
    offer_pair(24'sh800000, 24'sh7FFFFF);
    offer_pair(pick_sample(), pick_sample());
    wait_drain();
  endtask

  // rate and blend above one clamp, full gain saturates both ways
  task automatic test_saturation();
    write_all(3, 32'h1FFFF, 32'h1FFFFFF, 65535, 0);
    offer_pair(24'sh7FFFFF, 24'sh800000);
    offer_pair(24'sh800000, 24'sh7FFFFF);
    offer_pair(24'sh000001, 24'shFFFFFF);
    offer_pair(24'sh000000, 24'sh000000);
    offer_pair(24'sh1FFFFF, 24'shE00000);
    offer_pair(24'sh555555, 24'shAAAAAA);
    wait_drain();
    write_register(REG_OUTPUT_GAIN, 0);
    offer_pair(24'sh7FFFFF, 24'sh800000);
    offer_pair(pick_sample(), pick_sample());
    wait_drain();
  endtask

  // frozen captures keep pulling the averages at half blend
  task automatic test_freeze();
    write_register(REG_TARGET_BLEND, 32768);
    write_register(REG_OUTPUT_GAIN, 16384);
    write_register(REG_FREEZE, 1);
    for (int i = 0; i < 4; i++) offer_pair(pick_sample(), pick_sample());
    wait_drain();
    write_register(REG_FREEZE, 0);
    offer_random(2);
    wait_drain();
  endtask

  // writes to unmapped addresses must leave everything alone
  task automatic test_unknown_registers();
    for (int i = REG_FREEZE + 1; i < 8; i++) write_register(3'(i), 32'hFFFFFFFF);
    offer_random(2);
    wait_drain();
  endtask

  // longest and shortest loops, then a slow glide back down
  task automatic test_length_extremes();
    write_register(REG_TARGET_LENGTH, 65535);
    write_register(REG_GLIDE_RATE, RATE_ONE);
    offer_random(2);
    wait_drain();
    write_register(REG_TARGET_LENGTH, 1);
    offer_random(2);
    wait_drain();
    write_register(REG_TARGET_LENGTH, 0);
    write_register(REG_GLIDE_RATE, 32'h0040000);
    offer_random(2);
    wait_drain();
  endtask

  // result side held off while input keeps coming, then a full pause
  task automatic test_backpressure();
    write_all(5, 40000, 32'h0800000, 20000, 0);
    hold_request = 400;
    offer_random(40);
    wait_drain();
  endtask

  task automatic randomize_settings();
    logic [31:0] len_v, blend_v, rate_v, gain_v, frz_v;
    case ($urandom_range(3))
      0: len_v = $urandom_range(8);
      1: len_v = $urandom_range(64);
      2: len_v = $urandom_range(400, 1);
      default: len_v = $urandom_range(1) ? 65535 : $urandom_range(65535);
    endcase
    case ($urandom_range(4))
      0: rate_v = 0;
      1: rate_v = RATE_ONE;
      2: rate_v = 32'h1FFFFFF;
      3: rate_v = $urandom_range(32'h100000);
      default: rate_v = $urandom_range(32'h1FFFFFF);
    endcase
    case ($urandom_range(3))
      0: blend_v = 0;
      1: blend_v = BLEND_ONE;
      2: blend_v = 32'h1FFFF;
      default: blend_v = $urandom_range(32'h1FFFF);
    endcase
    case ($urandom_range(3))
      0: gain_v = 0;
      1: gain_v = 65535;
      2: gain_v = 16384;
      default: gain_v = $urandom_range(65535);
    endcase
    frz_v = ($urandom_range(99) < 20);
    write_all(len_v, blend_v, rate_v, gain_v, frz_v);
  endtask

  // random phases with fresh settings, one phase without any idling
  task automatic test_random_phases();
    for (int phase = 0; phase < 16; phase++) begin
      randomize_settings();
      steady = (phase == 7);
      offer_random($urandom_range(140, 60));
      wait_drain();
      steady = 1'b0;
    end
  endtask

  initial begin
    foreach (avg_left[i]) begin
      avg_left[i]  = '0;
      avg_right[i] = '0;
      cap_left[i]  = '0;
      cap_right[i] = '0;
    end
    loop_pos     = 0;
    smooth_len   = 0;
    smooth_blend = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    // memory clearing pass after reset
    @(negedge clk);
    while (!s_tready) @(negedge clk);

    test_reset_values();
    test_saturation();
    test_freeze();
    test_unknown_registers();
    test_length_extremes();
    test_backpressure();
    test_random_phases();

    wait_drain();
    repeat (20) @(negedge clk);
    if (err_count == 0 && expected_pairs.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
